// ===== rtl/ecp_pkg.sv =====
// Shared types and constants for the CSI escape sequence parser.
`default_nettype none
package ecp_pkg;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  text_byte;
    logic [31:0] first_arg;
    logic [31:0] second_arg;
  } out_t;

  // One step's outcome handed from the parser core to the output buffer
  typedef struct packed {
    logic valid;
    out_t data;
  } res_t;

  localparam logic [1:0] MODE_TEXT = 2'd0;
  localparam logic [1:0] MODE_ESC  = 2'd1;
  localparam logic [1:0] MODE_ARGS = 2'd2;
  localparam logic [1:0] MODE_SKIP = 2'd3;

  localparam logic [2:0] ACT_TEXT  = 3'd0;
  localparam logic [2:0] ACT_UP    = 3'd1;
  localparam logic [2:0] ACT_DOWN  = 3'd2;
  localparam logic [2:0] ACT_RIGHT = 3'd3;
  localparam logic [2:0] ACT_LEFT  = 3'd4;
  localparam logic [2:0] ACT_MOVE  = 3'd5;
  localparam logic [2:0] ACT_CLEAR = 3'd6;
  localparam logic [2:0] ACT_ERROR = 3'd7;

  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_ESC  = 8'h1b;
  localparam logic [7:0] CH_LBR  = 8'h5b;
  localparam logic [7:0] CH_SEMI = 8'h3b;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] CH_A    = 8'h41;
  localparam logic [7:0] CH_B    = 8'h42;
  localparam logic [7:0] CH_C    = 8'h43;
  localparam logic [7:0] CH_D    = 8'h44;
  localparam logic [7:0] CH_H    = 8'h48;
  localparam logic [7:0] CH_J    = 8'h4a;

  localparam logic [1:0]  CNT_MAX   = 2'd3;
  localparam logic [31:0] CLEAR_ARG = 32'd2;

endpackage
`default_nettype wire

// ===== rtl/ecp_core.sv =====
// Parser state and per-byte step logic: mode, number accumulator, saved arguments.
`default_nettype none
module ecp_core (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         step_en,
  input  wire ecp_pkg::in_t item,
  output ecp_pkg::res_t     res
);

  logic [1:0]  mode_r,   mode_nxt;
  logic        digit_r,  digit_nxt;
  logic [31:0] accum_r,  accum_nxt;
  logic [1:0]  cnt_r,    cnt_nxt;
  logic [31:0] first_r,  first_nxt;
  logic [31:0] second_r, second_nxt;

  logic [7:0]  b;
  logic        last;
  logic [31:0] digit_val;
  logic [31:0] accum_x10;
  // argument list as it stands once a pending number is finished
  logic [1:0]  f_cnt;
  logic [31:0] f_first;
  logic [31:0] f_second;
  logic [1:0]  c_cnt;
  logic [31:0] c_first;
  logic [31:0] c_second;
  logic [2:0]  cmd_act;

  assign b         = item.byte_in;
  assign last      = item.last_byte;
  assign digit_val = {24'd0, b - ecp_pkg::CH_0};
  assign accum_x10 = {accum_r[28:0], 3'b000} + {accum_r[30:0], 1'b0};

  assign f_first  = (cnt_r == 2'd0) ? accum_r : first_r;
  assign f_second = (cnt_r == 2'd1) ? accum_r : second_r;
  assign f_cnt    = (cnt_r == ecp_pkg::CNT_MAX) ? cnt_r : cnt_r + 2'd1;

  assign c_cnt    = digit_r ? f_cnt    : cnt_r;
  assign c_first  = digit_r ? f_first  : first_r;
  assign c_second = digit_r ? f_second : second_r;

  always_comb begin
    cmd_act = ecp_pkg::ACT_ERROR;
    case (b)
      ecp_pkg::CH_A: if (c_cnt == 2'd1) cmd_act = ecp_pkg::ACT_UP;
      ecp_pkg::CH_B: if (c_cnt == 2'd1) cmd_act = ecp_pkg::ACT_DOWN;
      ecp_pkg::CH_C: if (c_cnt == 2'd1) cmd_act = ecp_pkg::ACT_RIGHT;
      ecp_pkg::CH_D: if (c_cnt == 2'd1) cmd_act = ecp_pkg::ACT_LEFT;
      ecp_pkg::CH_H: if (c_cnt == 2'd2) cmd_act = ecp_pkg::ACT_MOVE;
      ecp_pkg::CH_J: begin
        if (c_cnt == 2'd1 && c_first == ecp_pkg::CLEAR_ARG) cmd_act = ecp_pkg::ACT_CLEAR;
      end
      default: cmd_act = ecp_pkg::ACT_ERROR;
    endcase
  end

  always_comb begin
    mode_nxt   = mode_r;
    digit_nxt  = digit_r;
    accum_nxt  = accum_r;
    cnt_nxt    = cnt_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    res        = '0;

    case (mode_r)
      ecp_pkg::MODE_TEXT: begin
        if (b == ecp_pkg::CH_ESC) begin
          mode_nxt = ecp_pkg::MODE_ESC;
        end else if (b != ecp_pkg::CH_NUL) begin
          res.valid          = 1'b1;
          res.data.action    = ecp_pkg::ACT_TEXT;
          res.data.text_byte = b;
        end
      end
      ecp_pkg::MODE_ESC: begin
        if (b == ecp_pkg::CH_LBR) begin
          mode_nxt   = ecp_pkg::MODE_ARGS;
          digit_nxt  = 1'b0;
          accum_nxt  = '0;
          cnt_nxt    = '0;
          first_nxt  = '0;
          second_nxt = '0;
          if (last) begin
            res.valid       = 1'b1;
            res.data.action = ecp_pkg::ACT_ERROR;
          end
        end else begin
          mode_nxt        = ecp_pkg::MODE_SKIP;
          res.valid       = 1'b1;
          res.data.action = ecp_pkg::ACT_ERROR;
        end
      end
      ecp_pkg::MODE_ARGS: begin
        if (b inside {[ecp_pkg::CH_0:ecp_pkg::CH_9]}) begin
          accum_nxt = accum_x10 + digit_val;
          digit_nxt = 1'b1;
          if (last) begin
            res.valid       = 1'b1;
            res.data.action = ecp_pkg::ACT_ERROR;
          end
        end else if (b == ecp_pkg::CH_SEMI) begin
          first_nxt  = f_first;
          second_nxt = f_second;
          cnt_nxt    = f_cnt;
          accum_nxt  = '0;
          digit_nxt  = 1'b0;
          if (last) begin
            res.valid       = 1'b1;
            res.data.action = ecp_pkg::ACT_ERROR;
          end
        end else begin
          // command byte: check the argument form, then clear the list
          res.valid       = 1'b1;
          res.data.action = cmd_act;
          if (cmd_act != ecp_pkg::ACT_ERROR && cmd_act != ecp_pkg::ACT_CLEAR) begin
            res.data.first_arg = c_first;
          end
          if (cmd_act == ecp_pkg::ACT_MOVE) res.data.second_arg = c_second;
          mode_nxt   = (cmd_act == ecp_pkg::ACT_ERROR) ? ecp_pkg::MODE_SKIP
                                                       : ecp_pkg::MODE_TEXT;
          digit_nxt  = 1'b0;
          accum_nxt  = '0;
          cnt_nxt    = '0;
          first_nxt  = '0;
          second_nxt = '0;
        end
      end
      default: begin
        // skip until the buffer ends
      end
    endcase

    if (last) begin
      mode_nxt   = ecp_pkg::MODE_TEXT;
      digit_nxt  = 1'b0;
      accum_nxt  = '0;
      cnt_nxt    = '0;
      first_nxt  = '0;
      second_nxt = '0;
    end

    if (!step_en) res.valid = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= ecp_pkg::MODE_TEXT;
      digit_r  <= 1'b0;
      accum_r  <= '0;
      cnt_r    <= '0;
      first_r  <= '0;
      second_r <= '0;
    end else if (step_en) begin
      mode_r   <= mode_nxt;
      digit_r  <= digit_nxt;
      accum_r  <= accum_nxt;
      cnt_r    <= cnt_nxt;
      first_r  <= first_nxt;
      second_r <= second_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ecma48_csi_escape_parser.sv =====
// Top level of the ECMA-48 CSI escape sequence parser with its output buffer.
`default_nettype none
// Parses a terminal byte stream, one byte per transfer, into text bytes and
// cursor/clear commands from ESC [ args cmd sequences. A byte is taken every
// cycle while in_ready is high: the parser step is one short combinational
// pass into the state registers, and a result lands in an output register
// backed by a one-entry skid stage, so in_ready drops only when both hold a
// result that the sink has not taken.
module ecma48_csi_escape_parser (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire ecp_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output ecp_pkg::out_t      out_data
);

  logic          step_en;
  ecp_pkg::res_t res;
  logic          pop;

  logic          out_valid_r,  out_valid_nxt;
  ecp_pkg::out_t out_data_r,   out_data_nxt;
  logic          skid_valid_r, skid_valid_nxt;
  ecp_pkg::out_t skid_data_r,  skid_data_nxt;

  assign in_ready  = !skid_valid_r;
  assign step_en   = in_valid && in_ready;
  assign pop       = out_valid_r && out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  ecp_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (in_data),
    .res     (res)
  );

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        // advance the skid entry, park any new result behind it
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = res.valid;
        skid_data_nxt  = res.data;
      end else begin
        out_valid_nxt = res.valid;
        out_data_nxt  = res.data;
      end
    end else if (res.valid) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = res.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

endmodule
`default_nettype wire

// ===== tb/tb_ecma48_csi_escape_parser.sv =====
// Self-checking testbench for the CSI escape sequence parser: byte stimulus, predictor, checker.
`timescale 1ns / 1ps

module tb_ecma48_csi_escape_parser;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD      = 250;
  localparam int TAIL_CYCLES    = 4;

  logic          clk       = 1'b0;
  logic          rst_n     = 1'b0;
  logic          in_valid  = 1'b0;
  logic          in_ready;
  ecp_pkg::in_t  in_data   = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  ecp_pkg::out_t out_data;

  ecma48_csi_escape_parser DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predicted parser state
  logic [1:0]  mode_q;
  logic        digits_pending;
  logic [31:0] number_q;
  logic [1:0]  args_done;
  logic [31:0] row_arg;
  logic [31:0] col_arg;

  ecp_pkg::out_t expected_actions[$];
  logic [7:0]    byte_run[$];
  int          mismatches     = 0;
  int          bytes_sent     = 0;
  int          send_idle_pct  = 0;
  int          recv_idle_pct  = 0;
  int          stall_requests = 0;
  int          stall_served   = 0;
  int          hold_left      = 0;
  int          quiet_cycles   = 0;

  task automatic add_byte(input logic [7:0] b);
    byte_run.insert(byte_run.size(), b);
  endtask

  task automatic clear_args();
    digits_pending = 1'b0;
    number_q       = '0;
    args_done      = '0;
    row_arg        = '0;
    col_arg        = '0;
  endtask

  task automatic close_arg();
    if (args_done == 2'd0) row_arg = number_q;
    else if (args_done == 2'd1) col_arg = number_q;
    if (args_done < ecp_pkg::CNT_MAX) args_done = args_done + 2'd1;
    number_q       = '0;
    digits_pending = 1'b0;
  endtask

  // Work out the action one accepted byte causes and queue it
  task automatic predict_action(input ecp_pkg::in_t item);
    ecp_pkg::out_t r;
    logic          has_r;
    logic [7:0]    b;
    has_r = 1'b0;
    r     = '0;
    b     = item.byte_in;
    case (mode_q)
      ecp_pkg::MODE_TEXT: begin
        if (b == ecp_pkg::CH_ESC) mode_q = ecp_pkg::MODE_ESC;
        else if (b != ecp_pkg::CH_NUL) begin
          has_r       = 1'b1;
          r.action    = ecp_pkg::ACT_TEXT;
          r.text_byte = b;
        end
      end
      ecp_pkg::MODE_ESC: begin
        has_r    = item.last_byte || (b != ecp_pkg::CH_LBR);
        r.action = ecp_pkg::ACT_ERROR;
        if (b == ecp_pkg::CH_LBR) begin
          clear_args();
          mode_q = ecp_pkg::MODE_ARGS;
        end else begin
          mode_q = ecp_pkg::MODE_SKIP;
        end
      end
      ecp_pkg::MODE_ARGS: begin
        if (b >= ecp_pkg::CH_0 && b <= ecp_pkg::CH_9) begin
          number_q       = number_q * 32'd10 + {24'd0, b - ecp_pkg::CH_0};
          digits_pending = 1'b1;
          has_r          = item.last_byte;
          r.action       = ecp_pkg::ACT_ERROR;
        end else if (b == ecp_pkg::CH_SEMI) begin
          close_arg();
          has_r    = item.last_byte;
          r.action = ecp_pkg::ACT_ERROR;
        end else begin
          if (digits_pending) close_arg();
          has_r    = 1'b1;
          r.action = ecp_pkg::ACT_ERROR;
          case (b)
            ecp_pkg::CH_A, ecp_pkg::CH_B, ecp_pkg::CH_C, ecp_pkg::CH_D: begin
              if (args_done == 2'd1) begin
                r.action    = (b == ecp_pkg::CH_A) ? ecp_pkg::ACT_UP :
                              (b == ecp_pkg::CH_B) ? ecp_pkg::ACT_DOWN :
                              (b == ecp_pkg::CH_C) ? ecp_pkg::ACT_RIGHT : ecp_pkg::ACT_LEFT;
                r.first_arg = row_arg;
              end
            end
            ecp_pkg::CH_H: begin
              if (args_done == 2'd2) begin
                r.action     = ecp_pkg::ACT_MOVE;
                r.first_arg  = row_arg;
                r.second_arg = col_arg;
              end
            end
            ecp_pkg::CH_J: begin
              if (args_done == 2'd1 && row_arg == ecp_pkg::CLEAR_ARG)
                r.action = ecp_pkg::ACT_CLEAR;
            end
            default: ;
          endcase
          clear_args();
          mode_q = (r.action == ecp_pkg::ACT_ERROR) ? ecp_pkg::MODE_SKIP : ecp_pkg::MODE_TEXT;
        end
      end
      default: ;
    endcase
    if (item.last_byte) begin
      mode_q = ecp_pkg::MODE_TEXT;
      clear_args();
    end
    if (has_r) expected_actions.insert(expected_actions.size(), r);
  endtask

  // Offer one byte and hold it until the transfer
  task automatic send_byte(input logic [7:0] b, input logic last);
    ecp_pkg::in_t item;
    item.byte_in   = b;
    item.last_byte = last;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_action(item);
    bytes_sent++;
  endtask

  task automatic send_run(input bit end_buf);
    for (int i = 0; i < byte_run.size(); i++)
      send_byte(byte_run[i], end_buf && (i == byte_run.size() - 1));
    byte_run.delete();
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (expected_actions.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic push_decimal(input logic [31:0] v);
    logic [7:0] digs [10];
    int k;
    k = 0;
    do begin
      digs[k] = ecp_pkg::CH_0 + 8'(v % 10);
      v = v / 10;
      k++;
    end while (v != 0);
    for (int i = k - 1; i >= 0; i--) add_byte(digs[i]);
  endtask

  task automatic push_arg();
    int form;
    form = $urandom_range(9);
    if (form >= 2 && form <= 5) push_decimal($urandom_range(20));
    else if (form == 6) push_decimal($urandom);
    else if (form == 7) push_decimal(32'hffff_ffff);
    else if (form >= 8) begin
      // long digit strings wrap the accumulator
      repeat ($urandom_range(10, 13)) add_byte(ecp_pkg::CH_0 + 8'($urandom_range(9)));
    end
  endtask

  task automatic build_csi();
    logic [7:0] cmd;
    int pick;
    int nargs;
    pick = $urandom_range(6);
    case (pick)
      0: cmd = ecp_pkg::CH_A;
      1: cmd = ecp_pkg::CH_B;
      2: cmd = ecp_pkg::CH_C;
      3: cmd = ecp_pkg::CH_D;
      4: cmd = ecp_pkg::CH_H;
      5: cmd = ecp_pkg::CH_J;
      default: begin
        do cmd = 8'($urandom_range(255));
        while ((cmd >= ecp_pkg::CH_0 && cmd <= ecp_pkg::CH_9) || cmd == ecp_pkg::CH_SEMI);
      end
    endcase
    add_byte(ecp_pkg::CH_ESC);
    add_byte(ecp_pkg::CH_LBR);
    if (cmd == ecp_pkg::CH_J && $urandom_range(1) == 1) begin
      push_decimal(ecp_pkg::CLEAR_ARG);
    end else begin
      if ($urandom_range(3) == 0) nargs = $urandom_range(4);
      else nargs = (cmd == ecp_pkg::CH_H) ? 2 : 1;
      for (int i = 0; i < nargs; i++) begin
        if (i != 0) add_byte(ecp_pkg::CH_SEMI);
        push_arg();
      end
    end
    add_byte(cmd);
  endtask

  task automatic build_broken();
    case ($urandom_range(3))
      0: begin
        add_byte(ecp_pkg::CH_ESC);
        add_byte(8'($urandom_range(255)));
      end
      1: add_byte(ecp_pkg::CH_ESC);
      2: begin
        add_byte(ecp_pkg::CH_ESC);
        add_byte(ecp_pkg::CH_LBR);
        if ($urandom_range(1) == 1) push_arg();
        if ($urandom_range(1) == 1) add_byte(ecp_pkg::CH_SEMI);
      end
      default: begin
        add_byte(ecp_pkg::CH_ESC);
        add_byte(ecp_pkg::CH_LBR);
        push_arg();
        add_byte(8'($urandom_range(32, 126)));
      end
    endcase
  endtask

  task automatic test_directed();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    byte_run = '{ecp_pkg::CH_NUL, 8'hff};
    send_run(1'b1);
    byte_run = '{ecp_pkg::CH_ESC, ecp_pkg::CH_LBR, ecp_pkg::CH_0 + 8'd7, ecp_pkg::CH_A};
    send_run(1'b0);
    byte_run = '{ecp_pkg::CH_ESC, ecp_pkg::CH_LBR, ecp_pkg::CH_0 + 8'd1, ecp_pkg::CH_SEMI,
                 ecp_pkg::CH_0 + 8'd2, ecp_pkg::CH_H};
    send_run(1'b0);
    byte_run = '{ecp_pkg::CH_ESC, ecp_pkg::CH_LBR, ecp_pkg::CH_0 + 8'd2, ecp_pkg::CH_J};
    send_run(1'b1);
    // unknown command ends the buffer on the same byte
    byte_run = '{ecp_pkg::CH_ESC, ecp_pkg::CH_LBR, 8'h5a};
    send_run(1'b1);
    // lone ESC at buffer end is dropped
    byte_run = '{ecp_pkg::CH_ESC};
    send_run(1'b1);
    byte_run = '{ecp_pkg::CH_ESC, 8'h78};
    send_run(1'b1);
    wait_drain();
  endtask

  task automatic test_random_traffic(input int n_bytes, input int s_idle, input int r_idle);
    int target;
    int kind;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) begin
      kind = $urandom_range(99);
      if (kind < 55) begin
        build_csi();
        send_run($urandom_range(2) == 0);
      end else if (kind < 80) begin
        repeat ($urandom_range(1, 6))
          add_byte(($urandom_range(9) == 0) ? ecp_pkg::CH_NUL : 8'($urandom_range(255)));
        send_run($urandom_range(6) == 0);
      end else if (kind < 90) begin
        build_broken();
        send_run($urandom_range(1) == 1);
      end else begin
        add_byte(8'($urandom_range(255)));
        send_run(1'b1);
      end
    end
    wait_drain();
  endtask

  task automatic test_output_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_requests++;
    // keep offering text so the output side fills and in_ready drops
    repeat (40) begin
      add_byte(8'($urandom_range(32, 126)));
      send_run(1'b0);
    end
    wait_drain();
  endtask

  // Receiver: random idling plus a long hold on request
  always @(posedge clk) begin
    if (stall_requests != stall_served) begin
      stall_served = stall_requests;
      hold_left    = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : check_results
    ecp_pkg::out_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (expected_actions.size() == 0) begin
        $error("unexpected result: action %0d text_byte %0h", out_data.action,
               out_data.text_byte);
        mismatches++;
      end else begin
        exp_r = expected_actions.pop_front();
        if (out_data.action !== exp_r.action) begin
          $error("action: expected %0d, got %0d", exp_r.action, out_data.action);
          mismatches++;
        end
        if (out_data.text_byte !== exp_r.text_byte) begin
          $error("text_byte: expected %0h, got %0h", exp_r.text_byte, out_data.text_byte);
          mismatches++;
        end
        if (out_data.first_arg !== exp_r.first_arg) begin
          $error("first_arg: expected %0d, got %0d", exp_r.first_arg, out_data.first_arg);
          mismatches++;
        end
        if (out_data.second_arg !== exp_r.second_arg) begin
          $error("second_arg: expected %0d, got %0d", exp_r.second_arg, out_data.second_arg);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else if (rst_n) quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    mode_q = ecp_pkg::MODE_TEXT;
    clear_args();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_traffic(400, 6, 62);
    test_output_stall();
    test_random_traffic(400, 62, 6);
    test_random_traffic(400, 0, 0);
    if (mismatches == 0 && expected_actions.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ecp_pkg.sv
rtl/ecp_core.sv
rtl/ecma48_csi_escape_parser.sv
tb/tb_ecma48_csi_escape_parser.sv
